@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a condition in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mat_pkg.sv @@
// Shared types, codes and constants of the multistep attack tracker.
package mat_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam logic [31:0] EXPIRY_RESET = 32'd60;

  // Event kinds
  localparam logic [1:0] FUNC_SSH   = 2'd0;
  localparam logic [1:0] FUNC_HTTP  = 2'd1;
  localparam logic [1:0] FUNC_FTP   = 2'd2;
  localparam logic [1:0] FUNC_OTHER = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ADVANCED = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  // Tracking stages
  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_SSH  = 2'd2;
  localparam logic [1:0] STAGE_HTTP = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] src_ip;
    logic [31:0] now_sec;
  } in_word_t;

  typedef struct packed {
    logic       alert;
    logic [2:0] status;
    logic       expired;
    logic [1:0] stage_after;
  } out_word_t;

  // One table entry as stored in the memory
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [1:0]  stage;
    logic [31:0] created;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_APPLY
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic check;
    logic apply;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_end;
    logic item_unknown;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/multistep_attack_tracker.sv @@
// A word whose source sits at table index k stops the scan there; a miss or a new source is
// answered after a scan of the whole table memory through its single read port, one entry
// per cycle. An event kind 3 skips the scan. A new word is taken only once the last result is
// in the output register; the next word is accepted while that result waits.
// Reset (synchronous, rst_n low): expiry returns to 60 s, then a clearing pass empties every
// table entry; no input word is accepted during it.
`include "assert_macros.svh"

module multistep_attack_tracker #(
  parameter int TABLE_ENTRIES = mat_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mat_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mat_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  mat_pkg::ctrl_cmd_t cmd;
  mat_pkg::dp_stat_t  stat;

  // Register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Sequencer
  mat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table and result datapath
  mat_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Commands to the datapath never overlap
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "overlapping datapath commands")
  // A result is only loaded when the output register can take it
  `ASSERT_SAME(a_apply_free, cmd.apply, stat.out_free, "result loaded over a pending word")
  // After a word is accepted the input side stalls while it is processed
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  // A scan never reports a match and a miss together
  `ASSERT_SAME(a_hit_xor_end, stat.scan_hit, !stat.scan_end, "scan hit and miss together")

endmodule

@@ hw/rtl/mat_ctrl.sv @@
// Sequencing state machine: clear pass, table scan, expiry check, update.
module mat_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mat_pkg::dp_stat_t    stat,
  output mat_pkg::ctrl_cmd_t   cmd
);

  mat_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mat_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mat_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = mat_pkg::S_IDLE;
      end
      mat_pkg::S_IDLE: begin
        if (in_valid) state_nxt = mat_pkg::S_SCAN;
      end
      mat_pkg::S_SCAN: begin
        if (stat.item_unknown || stat.scan_hit || stat.scan_end) state_nxt = mat_pkg::S_CHECK;
      end
      mat_pkg::S_CHECK: begin
        state_nxt = mat_pkg::S_APPLY;
      end
      mat_pkg::S_APPLY: begin
        if (stat.out_free) state_nxt = mat_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mat_pkg::S_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      mat_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
      end
      mat_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mat_pkg::S_SCAN: begin
        cmd.scan = !stat.item_unknown;
      end
      mat_pkg::S_CHECK: begin
        cmd.check = 1'b1;
      end
      mat_pkg::S_APPLY: begin
        cmd.apply = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/mat_dp.sv @@
// Datapath: entry table memory, scan pointers, expiry compare, result register.
module mat_dp #(
  parameter int TABLE_ENTRIES = mat_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mat_pkg::ctrl_cmd_t   cmd,
  output mat_pkg::dp_stat_t    stat,
  input  mat_pkg::in_word_t    in_word,
  input  logic                 cfg_valid,
  input  logic [31:0]          cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output mat_pkg::out_word_t   out_word
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [PW-1:0] NUM_ENTRIES = PW'(TABLE_ENTRIES);

  mat_pkg::entry_t mem [TABLE_ENTRIES];

  mat_pkg::in_word_t  item_r;
  mat_pkg::entry_t    rd_data_r;
  logic [31:0]        expiry_r;
  logic [IW-1:0]      clr_ptr_r;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic [1:0]         hit_stage_r;
  logic [31:0]        hit_created_r;
  logic               free_found_r;
  logic [IW-1:0]      free_idx_r;
  logic               exp_r;
  logic               exp_nxt;
  logic               out_valid_r;
  mat_pkg::out_word_t out_word_r;

  logic               scan_hit;
  logic               scan_free;
  logic [31:0]        age;
  logic               hit_live;
  logic               slot_ok;
  logic [IW-1:0]      slot_idx;
  mat_pkg::out_word_t res;
  logic               ap_we;
  logic [IW-1:0]      ap_addr;
  mat_pkg::entry_t    ap_data;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  mat_pkg::entry_t    mem_wdata;

  // Expiry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= mat_pkg::EXPIRY_RESET;
    end else if (cfg_valid) begin
      expiry_r <= cfg_data;
    end
  end

  // Event word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
    end
  end

  // Clearing pass pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clr) begin
      clr_ptr_r <= clr_ptr_r + IW'(1);
    end
  end

  // Scan: one read issued per cycle, checked in the cycle after it
  always_comb begin
    rd_ptr_nxt  = rd_ptr_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    if (cmd.load) begin
      rd_ptr_nxt = '0;
    end else if (cmd.scan && (rd_ptr_r < NUM_ENTRIES)) begin
      rd_ptr_nxt  = rd_ptr_r + PW'(1);
      chk_vld_nxt = 1'b1;
      chk_idx_nxt = rd_ptr_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      rd_ptr_r  <= rd_ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
  end

  assign scan_hit  = chk_vld_r && rd_data_r.valid && (rd_data_r.addr == item_r.src_ip);
  assign scan_free = chk_vld_r && !rd_data_r.valid;

  // Hit and lowest free slot tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_hit) hit_r <= 1'b1;
      if (scan_free && !free_found_r) free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_hit) begin
      hit_idx_r     <= chk_idx_r;
      hit_stage_r   <= rd_data_r.stage;
      hit_created_r <= rd_data_r.created;
    end
    if (cmd.scan && scan_free && !free_found_r) begin
      free_idx_r <= chk_idx_r;
    end
  end

  // Expiry check on the matched entry (wrapping age)
  assign age     = item_r.now_sec - hit_created_r;
  assign exp_nxt = hit_r && (age > expiry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 1'b0;
    end else if (cmd.check) begin
      exp_r <= exp_nxt;
    end
  end

  // Table update and result for the event
  assign hit_live = hit_r && !exp_r;
  assign slot_ok  = free_found_r || exp_r;
  assign slot_idx = free_found_r ? free_idx_r : hit_idx_r;

  always_comb begin
    res             = '0;
    res.status      = mat_pkg::ST_NONE;
    res.expired     = exp_r;
    res.stage_after = mat_pkg::STAGE_NONE;
    ap_we           = 1'b0;
    ap_addr         = hit_idx_r;
    ap_data.valid   = 1'b1;
    ap_data.addr    = item_r.src_ip;
    ap_data.stage   = hit_stage_r;
    ap_data.created = hit_created_r;
    unique case (item_r.func)
      mat_pkg::FUNC_SSH: begin
        if (hit_live) begin
          res.stage_after = hit_stage_r;
        end else if (slot_ok) begin
          ap_we           = 1'b1;
          ap_addr         = slot_idx;
          ap_data.stage   = mat_pkg::STAGE_SSH;
          ap_data.created = item_r.now_sec;
          res.status      = mat_pkg::ST_ADDED;
          res.stage_after = mat_pkg::STAGE_SSH;
        end else begin
          res.status = mat_pkg::ST_FULL;
        end
      end
      mat_pkg::FUNC_HTTP: begin
        if (hit_live) begin
          if (hit_stage_r == mat_pkg::STAGE_SSH) begin
            ap_we           = 1'b1;
            ap_data.stage   = mat_pkg::STAGE_HTTP;
            res.status      = mat_pkg::ST_ADVANCED;
            res.stage_after = mat_pkg::STAGE_HTTP;
          end else begin
            res.stage_after = hit_stage_r;
          end
        end
      end
      mat_pkg::FUNC_FTP: begin
        if (hit_live) begin
          if (hit_stage_r == mat_pkg::STAGE_HTTP) begin
            ap_we         = 1'b1;
            ap_data.valid = 1'b0;
            res.alert     = 1'b1;
            res.status    = mat_pkg::ST_ADVANCED;
          end else begin
            res.stage_after = hit_stage_r;
          end
        end
      end
      default: begin
        res.status  = mat_pkg::ST_UNKNOWN;
        res.expired = 1'b0;
      end
    endcase
  end

  // Memory write port select: clearing pass, expiry removal, event update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ap_addr;
    mem_wdata = ap_data;
    if (cmd.clr) begin
      mem_we          = 1'b1;
      mem_waddr       = clr_ptr_r;
      mem_wdata       = '0;
    end else if (cmd.check) begin
      mem_we          = exp_nxt;
      mem_waddr       = hit_idx_r;
      mem_wdata       = ap_data;
      mem_wdata.valid = 1'b0;
    end else if (cmd.apply) begin
      mem_we = ap_we;
    end
  end

  // Entry table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_ptr_r[IW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Status to controller
  assign stat.clr_last     = (clr_ptr_r == LAST_IDX);
  assign stat.scan_hit     = scan_hit;
  assign stat.scan_end     = chk_vld_r && (chk_idx_r == LAST_IDX) && !scan_hit;
  assign stat.item_unknown = (item_r.func == mat_pkg::FUNC_OTHER);
  assign stat.out_free     = !out_valid_r || !out_stall;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the multistep attack tracker.
`timescale 1ns / 1ps

// Predicts tracker results from accepted event words and checks result words in order
class attack_scoreboard;
  localparam int SLOTS = mat_pkg::DEF_TABLE_ENTRIES;

  logic [31:0]          expiry;
  bit                   live [SLOTS];
  logic [31:0]          addr [SLOTS];
  logic [1:0]           stage [SLOTS];
  logic [31:0]          born [SLOTS];
  mat_pkg::out_word_t   expected_q [$];
  int                   errors;

  function new();
    expiry = mat_pkg::EXPIRY_RESET;
    errors = 0;
    foreach (live[i]) live[i] = 1'b0;
  endfunction

  // One line per mismatch, and a count
  task report(string what, int want, int got);
    $display("%0t: mismatch %s: expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  // Update the tracked-source table for one accepted event and queue its result
  function void note_event(mat_pkg::in_word_t w);
    mat_pkg::out_word_t r;
    logic [31:0]        age;
    int                 hit;
    int                 slot;
    bit                 found;
    r = '0;
    hit = -1;
    slot = -1;
    found = 1'b0;
    if (w.func == mat_pkg::FUNC_OTHER) begin
      r.status = mat_pkg::ST_UNKNOWN;
    end else begin
      // lookup from index 0 upward; a stale match is dropped
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && live[i] && addr[i] == w.src_ip) begin
          found = 1'b1;
          age = w.now_sec - born[i];
          if (age > expiry) begin
            live[i] = 1'b0;
            r.expired = 1'b1;
          end else begin
            hit = i;
          end
        end
      end
      case (w.func)
        mat_pkg::FUNC_SSH: begin
          if (hit >= 0) begin
            r.stage_after = stage[hit];
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--)
              if (!live[i]) slot = i;
            if (slot >= 0) begin
              live[slot] = 1'b1;
              addr[slot] = w.src_ip;
              stage[slot] = mat_pkg::STAGE_SSH;
              born[slot] = w.now_sec;
              r.status = mat_pkg::ST_ADDED;
              r.stage_after = mat_pkg::STAGE_SSH;
            end else begin
              r.status = mat_pkg::ST_FULL;
            end
          end
        end
        mat_pkg::FUNC_HTTP: begin
          if (hit >= 0) begin
            if (stage[hit] == mat_pkg::STAGE_SSH) begin
              stage[hit] = mat_pkg::STAGE_HTTP;
              r.status = mat_pkg::ST_ADVANCED;
            end
            r.stage_after = stage[hit];
          end
        end
        default: begin
          if (hit >= 0) begin
            if (stage[hit] == mat_pkg::STAGE_HTTP) begin
              live[hit] = 1'b0;
              r.alert = 1'b1;
              r.status = mat_pkg::ST_ADVANCED;
              r.stage_after = mat_pkg::STAGE_NONE;
            end else begin
              r.stage_after = stage[hit];
            end
          end
        end
      endcase
    end
    expected_q.push_back(r);
  endfunction

  // Compare one accepted result word with the oldest prediction
  task check_result(mat_pkg::out_word_t got);
    mat_pkg::out_word_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result word, status", 0, int'(got.status));
    end else begin
      want = expected_q.pop_front();
      if (got.alert !== want.alert) report("alert", int'(want.alert), int'(got.alert));
      if (got.status !== want.status) report("status", int'(want.status), int'(got.status));
      if (got.expired !== want.expired)
        report("expired", int'(want.expired), int'(got.expired));
      if (got.stage_after !== want.stage_after)
        report("stage_after", int'(want.stage_after), int'(got.stage_after));
    end
  endtask
endclass

module testbench;

  localparam int          POOL = 80;
  localparam int unsigned LIMIT = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mat_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  mat_pkg::out_word_t out_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  attack_scoreboard sb;
  int unsigned      cycle_count;
  int               idle_pct;
  int               stall_pct;
  logic [31:0]      clock_sec;
  logic [31:0]      src_pool [POOL];
  logic [1:0]       next_step [POOL];

  multistep_attack_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_word);
      if (in_valid && !in_stall) sb.note_event(in_word);
    end
  end

  function automatic mat_pkg::in_word_t mk_word(logic [1:0] f, logic [31:0] ip,
                                                logic [31:0] t);
    mat_pkg::in_word_t w;
    w.func = f;
    w.src_ip = ip;
    w.now_sec = t;
    return w;
  endfunction

  // Mostly per-source SSH/HTTP/FTP sequences, with noise and stray sources mixed in
  function automatic mat_pkg::in_word_t random_word();
    mat_pkg::in_word_t w;
    int                r;
    int                k;
    r = $urandom_range(99);
    k = $urandom_range(POOL - 1);
    if ($urandom_range(99) == 0) clock_sec += $urandom_range(1000);
    else if ($urandom_range(3) == 0) clock_sec += 1;
    w.now_sec = clock_sec;
    w.src_ip = src_pool[k];
    if (r < 80) begin
      w.func = next_step[k];
      next_step[k] = (next_step[k] == mat_pkg::FUNC_FTP) ? mat_pkg::FUNC_SSH
                                                         : next_step[k] + 2'd1;
    end else if (r < 88) begin
      w.func = 2'($urandom_range(3));
    end else if (r < 93) begin
      w.func = mat_pkg::FUNC_OTHER;
      w.src_ip = $urandom;
    end else if (r < 99) begin
      w.func = 2'($urandom_range(1, 3));
      w.src_ip = $urandom;
    end else begin
      w.func = mat_pkg::FUNC_SSH;
      w.src_ip = $urandom;
    end
    if ($urandom_range(49) == 0) w.now_sec = $urandom;
    return w;
  endfunction

  // Drive one event word, hold it until taken, then maybe idle a while
  task send_event(mat_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // At least one edge passes so the last accepted word is already noted
  task wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task write_expiry(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.expiry = v;
  endtask

  task run_random(int n);
    for (int i = 0; i < n; i++) send_event(random_word());
  endtask

  initial begin
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    clock_sec = 32'd1000;
    sb = new();
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL; i++) src_pool[i] = $urandom;
    foreach (next_step[i]) next_step[i] = mat_pkg::FUNC_SSH;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every event kind, stage transitions, expiry edge and time wrap
    send_event(mk_word(mat_pkg::FUNC_OTHER, 32'h0000_0000, 32'hFFFF_FFFF));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'hFFFF_FFFF, 32'd100));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'hFFFF_FFFF, 32'd100));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'hFFFF_FFFF, 32'd100));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'hFFFF_FFFF, 32'd101));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'hFFFF_FFFF, 32'd102));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'hFFFF_FFFF, 32'd103));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'hFFFF_FFFF, 32'd104));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'hFFFF_FFFF, 32'd105));
    send_event(mk_word(mat_pkg::FUNC_OTHER, 32'hFFFF_FFFF, 32'd106));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'hFFFF_FFFF, 32'd107));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'hFFFF_FFFF, 32'd108));
    // stale entry on HTTP, then stale entry replaced on SSH
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'h0000_0000, 32'd200));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'h0000_0000, 32'd261));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'h8000_0001, 32'd300));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'h8000_0001, 32'd361));
    // age exactly at the limit is still live; beyond it is not
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'h7FFF_FFFE, 32'd400));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'h7FFF_FFFE, 32'd460));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'h7FFF_FFFE, 32'd521));
    // full sequence across the seconds wrap
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'hA5A5_5A5A, 32'hFFFF_FFF0));
    send_event(mk_word(mat_pkg::FUNC_HTTP, 32'hA5A5_5A5A, 32'h0000_0010));
    send_event(mk_word(mat_pkg::FUNC_FTP, 32'hA5A5_5A5A, 32'h0000_002C));
    send_event(mk_word(mat_pkg::FUNC_SSH, 32'h0000_0000, 32'h0000_0000));
    send_event(mk_word(mat_pkg::FUNC_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_results();

    // No expiry: start every pooled source to overflow the table, then mix
    write_expiry(32'hFFFF_FFFF);
    clock_sec = 32'hFFFF_FF00;
    for (int i = 0; i < POOL; i++) begin
      send_event(mk_word(mat_pkg::FUNC_SSH, src_pool[i], clock_sec));
      next_step[i] = mat_pkg::FUNC_HTTP;
    end
    run_random(200);
    wait_results();

    // Zero expiry, sender gaps
    write_expiry(32'd0);
    idle_pct = 50;
    run_random(270);
    wait_results();

    // Reset expiry value again, receiver stalls
    write_expiry(mat_pkg::EXPIRY_RESET);
    idle_pct = 0;
    stall_pct = 50;
    run_random(270);
    wait_results();

    // Short random expiry, both sides idle
    write_expiry($urandom_range(1, 300));
    idle_pct = 15;
    stall_pct = 15;
    run_random(270);
    wait_results();

    // Arbitrary expiry, full rate
    write_expiry($urandom);
    idle_pct = 0;
    stall_pct = 0;
    run_random(270);
    wait_results();

    repeat (mat_pkg::DEF_TABLE_ENTRIES + 10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/mat_pkg.sv
hw/rtl/mat_ctrl.sv
hw/rtl/mat_dp.sv
hw/rtl/multistep_attack_tracker.sv
dv/testbench.sv
